// ===== sv/tet_pkg.sv =====
// Shared types and constants for the timed event table.
// Used by tet_cell, timed_event_table_unit, tet_checker and the testbench; no dependencies.
`default_nettype none

package tet_pkg;

  localparam int SLOTS   = 16;
  localparam int MAX_OUT = 16;

  localparam int SLOT_W = 7;
  localparam int KEY_W  = 28;
  localparam int STEP_W = $clog2(SLOTS + 1);
  localparam int FIRE_W = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_BADPAR  = 3'd2,
    ST_DELETED = 3'd3,
    ST_BADSLOT = 3'd4,
    ST_FIRED   = 3'd5,
    ST_NONE    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  // One stored event: action and time key (year, month, day, hour, minute)
  typedef struct packed {
    logic             cmd;
    logic [2:0]       outp;
    logic [1:0]       color;
    logic [KEY_W-1:0] tkey;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

  // One result item
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              cmd;
    logic [2:0]        outp;
    logic [1:0]        color;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/tet_cell.sv =====
// One slot of the rotating event chain: occupancy flag and stored event.
// Depends on tet_pkg.
`default_nettype none

module tet_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tet_pkg::cell_ctl_t ctl,
  input  wire logic             d_occ,
  input  wire tet_pkg::entry_t  d_ent,
  output logic                  q_occ,
  output tet_pkg::entry_t       q_ent
);
  import tet_pkg::*;

  logic   occ_r;
  entry_t ent_r;

  // Take the neighbour's slot on a shift; drop occupancy on a delete
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctl.shift) begin
      occ_r <= d_occ;
    end else if (ctl.clr) begin
      occ_r <= 1'b0;
    end
  end

  // Event payload follows the shift, no reset
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent_r <= d_ent;
    end
  end

  assign q_occ = occ_r;
  assign q_ent = ent_r;

endmodule

`default_nettype wire

// ===== sv/timed_event_table_unit.sv =====
// Top level of the timed event table: sequencer, rotating slot chain, output register.
// Depends on tet_pkg and tet_cell.
`default_nettype none

// Holds SLOTS scheduled events in a ring of cells that, while a scan runs and is
// not stalled, rotates one place per cycle past a head cell, where the sequencer
// inspects and rewrites the slot. Add and check requests each walk the whole ring
// (adds rejected for bad parameters excepted), so they occupy the sequencer for
// acceptance, a scan of every slot and the hand-over of the final result, and
// the ring is back in slot order at the end. Deletes and rejected adds go from
// acceptance straight to the hand-over. A check stalls the ring while a fired
// result cannot be handed to the output register, so back-pressure on out_ready
// lengthens it by the cycles spent waiting. Only one request is in progress at a
// time; in_ready is high whenever the sequencer is idle, even if the last result
// still sits in the output register. Results carry last on the final one.

module timed_event_table_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_op,
  input  wire logic [3:0]                in_command_code,
  input  wire logic [3:0]                in_output_number,
  input  wire logic [3:0]                in_color_code,
  input  wire logic [tet_pkg::SLOT_W-1:0] in_slot_index,
  input  wire logic [7:0]                in_time_year,
  input  wire logic [3:0]                in_time_month,
  input  wire logic [4:0]                in_time_day,
  input  wire logic [4:0]                in_time_hour,
  input  wire logic [5:0]                in_time_minute,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [2:0]                     out_status,
  output logic [tet_pkg::SLOT_W-1:0]     out_slot,
  output logic                           out_fired_command,
  output logic [2:0]                     out_fired_output,
  output logic [1:0]                     out_fired_color,
  output logic                           out_last
);
  import tet_pkg::*;

  // Sequencer state
  fsm_t              state_r, state_nxt;
  op_t               op_r;
  logic [KEY_W-1:0]  now_key_r;
  entry_t            new_ent_r;
  logic              direct_r;
  status_t           dir_status_r;
  logic [SLOT_W-1:0] dir_slot_r;
  logic [STEP_W-1:0] step_r;
  logic              found_r;
  logic [SLOT_W-1:0] found_slot_r;
  logic [FIRE_W-1:0] fire_cnt_r;
  logic              hold_valid_r;
  result_t           hold_r;
  logic              out_valid_r;
  result_t           out_r;

  // Chain wiring
  logic      cell_occ [SLOTS];
  entry_t    cell_ent [SLOTS];
  cell_ctl_t cell_ctl [SLOTS];
  logic      tail_occ;
  entry_t    tail_ent;

  // Decoded control
  logic    in_acc;
  logic    bad_par;
  logic    due;
  logic    add_here;
  logic    out_free;
  logic    stall;
  logic    advance;
  logic    last_step;
  logic    push_hold;
  logic    final_load;
  logic    del_acc;
  result_t final_res;

  assign in_acc  = in_valid && in_ready;
  assign bad_par = (in_command_code > 4'd1) || (in_output_number > 4'd7)
                   || (in_color_code > 4'd3);
  assign del_acc = in_acc && (op_t'(in_op) == OP_DEL);

  // Inspect the head cell
  always_comb begin
    due = (op_r == OP_CHECK) && cell_occ[0]
          && (now_key_r >= cell_ent[0].tkey)
          && (fire_cnt_r < FIRE_W'(MAX_OUT));
    add_here  = (op_r == OP_ADD) && !found_r && !cell_occ[0];
    last_step = (step_r == STEP_W'(SLOTS - 1));
  end

  // Control outputs of the sequencer
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    in_ready   = (state_r == FSM_IDLE);
    stall      = due && hold_valid_r && !out_free;
    advance    = (state_r == FSM_SCAN) && !stall;
    push_hold  = advance && due && hold_valid_r;
    final_load = (state_r == FSM_DONE) && out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_op))
            OP_ADD:   state_nxt = bad_par ? FSM_DONE : FSM_SCAN;
            OP_DEL:   state_nxt = FSM_DONE;
            OP_CHECK: state_nxt = FSM_SCAN;
            default:  state_nxt = FSM_IDLE;
          endcase
        end
      end
      FSM_SCAN: begin
        if (advance && last_step) begin
          state_nxt = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Rewrite the head slot as it moves round to the tail
  always_comb begin
    tail_occ = cell_occ[0];
    tail_ent = cell_ent[0];
    if (add_here) begin
      tail_occ = 1'b1;
      tail_ent = new_ent_r;
    end else if (due) begin
      tail_occ = 1'b0;
    end
  end

  // Ring of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cell_ctl[i].shift = advance;
    assign cell_ctl[i].clr   = del_acc && (in_slot_index == SLOT_W'(i));

    if (i == SLOTS - 1) begin : g_tail
      tet_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cell_ctl[i]),
        .d_occ (tail_occ),
        .d_ent (tail_ent),
        .q_occ (cell_occ[i]),
        .q_ent (cell_ent[i])
      );
    end else begin : g_mid
      tet_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cell_ctl[i]),
        .d_occ (cell_occ[i+1]),
        .d_ent (cell_ent[i+1]),
        .q_occ (cell_occ[i]),
        .q_ent (cell_ent[i])
      );
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r           <= op_t'(in_op);
      now_key_r      <= {in_time_year, in_time_month, in_time_day,
                         in_time_hour, in_time_minute};
      new_ent_r.cmd   <= in_command_code[0];
      new_ent_r.outp  <= in_output_number[2:0];
      new_ent_r.color <= in_color_code[1:0];
      new_ent_r.tkey  <= {in_time_year, in_time_month, in_time_day,
                          in_time_hour, in_time_minute};
      direct_r     <= (op_t'(in_op) == OP_DEL) || ((op_t'(in_op) == OP_ADD) && bad_par);
      dir_slot_r   <= (op_t'(in_op) == OP_DEL) ? in_slot_index : '0;
      if (op_t'(in_op) == OP_DEL) begin
        dir_status_r <= (in_slot_index < SLOT_W'(SLOTS)) ? ST_DELETED : ST_BADSLOT;
      end else begin
        dir_status_r <= ST_BADPAR;
      end
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      hold_valid_r <= 1'b0;
      step_r       <= '0;
      fire_cnt_r   <= '0;
    end else if (in_acc) begin
      found_r      <= 1'b0;
      hold_valid_r <= 1'b0;
      step_r       <= '0;
      fire_cnt_r   <= '0;
    end else if (advance) begin
      step_r <= step_r + STEP_W'(1);
      if (add_here) begin
        found_r <= 1'b1;
      end
      if (due) begin
        hold_valid_r <= 1'b1;
        fire_cnt_r   <= fire_cnt_r + FIRE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && add_here) begin
      found_slot_r <= SLOT_W'(step_r);
    end
    if (advance && due) begin
      hold_r.status <= ST_FIRED;
      hold_r.slot   <= SLOT_W'(step_r);
      hold_r.cmd    <= cell_ent[0].cmd;
      hold_r.outp   <= cell_ent[0].outp;
      hold_r.color  <= cell_ent[0].color;
      hold_r.last   <= 1'b0;
    end
  end

  // Final result of the request
  always_comb begin
    final_res = '0;
    final_res.status = ST_NONE;
    if (direct_r) begin
      final_res.status = dir_status_r;
      final_res.slot   = dir_slot_r;
    end else if (op_r == OP_ADD) begin
      final_res.status = found_r ? ST_ADDED : ST_FULL;
      final_res.slot   = found_r ? found_slot_r : '0;
    end else if (hold_valid_r) begin
      final_res = hold_r;
    end
    final_res.last = 1'b1;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_hold || final_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_hold) begin
      out_r <= hold_r;
    end else if (final_load) begin
      out_r <= final_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_slot          = out_r.slot;
  assign out_fired_command = out_r.cmd;
  assign out_fired_output  = out_r.outp;
  assign out_fired_color   = out_r.color;
  assign out_last          = out_r.last;

endmodule

`default_nettype wire

// ===== sv/tet_checker.sv =====
// Port-level checks for timed_event_table_unit, bound to the top level.
// Depends on tet_pkg.
`default_nettype none

module tet_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [2:0]                  out_status,
  input wire logic [tet_pkg::SLOT_W-1:0]  out_slot,
  input wire logic                        out_fired_command,
  input wire logic [2:0]                  out_fired_output,
  input wire logic [1:0]                  out_fired_color,
  input wire logic                        out_last
);
  import tet_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot)
      && $stable(out_last))
    else $error("stalled result changed");

  // Only defined status codes appear
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NONE)
    else $error("undefined status code");

  // Event fields are zero unless an event fired
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FIRED |->
      !out_fired_command && out_fired_output == 3'd0 && out_fired_color == 2'd0)
    else $error("event fields set on non-fired result");

  // Every result other than a fired event closes its request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FIRED |-> out_last)
    else $error("single result without last");

endmodule

bind timed_event_table_unit tet_checker u_tet_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_slot          (out_slot),
  .out_fired_command (out_fired_command),
  .out_fired_output  (out_fired_output),
  .out_fired_color   (out_fired_color),
  .out_last          (out_last)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for timed_event_table_unit: directed and random add, delete and
// check requests, with random idling on both handshakes and a scoreboard class.
// Depends on tet_pkg and the timed_event_table_unit RTL.
`timescale 1ns / 1ps

// One request as driven on the input channel
typedef struct packed {
  logic [1:0]                 op;
  logic [3:0]                 cmd;
  logic [3:0]                 outp;
  logic [3:0]                 color;
  logic [tet_pkg::SLOT_W-1:0] idx;
  logic [7:0]                 year;
  logic [3:0]                 month;
  logic [4:0]                 day;
  logic [4:0]                 hour;
  logic [5:0]                 minute;
} event_request_t;

// Mirror of the slot table plus the queue of results it still owes
class event_table_board;
  bit                 occupied [tet_pkg::SLOTS];
  tet_pkg::entry_t    stored   [tet_pkg::SLOTS];
  tet_pkg::result_t   owed_results [$];
  int                 mismatches;

  function new();
    for (int i = 0; i < tet_pkg::SLOTS; i++) begin
      occupied[i] = 1'b0;
      stored[i]   = '0;
    end
    mismatches = 0;
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  task report(input string msg);
    $display("tb: mismatch: %s", msg);
    mismatches++;
  endtask

  function void owe(input tet_pkg::status_t status, input logic [tet_pkg::SLOT_W-1:0] slot,
                    input logic cmd, input logic [2:0] outp, input logic [1:0] color);
    tet_pkg::result_t r;
    r.status = status;
    r.slot   = slot;
    r.cmd    = cmd;
    r.outp   = outp;
    r.color  = color;
    r.last   = 1'b0;
    owed_results.push_back(r);
  endfunction

  // Apply one accepted request to the table and queue the results it causes
  function void apply_request(input event_request_t req);
    logic [tet_pkg::KEY_W-1:0]  now_key;
    logic [tet_pkg::SLOT_W-1:0] s;
    int                         found;
    int                         fired;
    now_key = {req.year, req.month, req.day, req.hour, req.minute};
    found   = -1;
    fired   = 0;
    case (req.op)
      tet_pkg::OP_ADD: begin
        if (req.cmd > 4'd1 || req.outp > 4'd7 || req.color > 4'd3) begin
          owe(tet_pkg::ST_BADPAR, '0, 1'b0, 3'd0, 2'd0);
        end else begin
          for (int i = tet_pkg::SLOTS - 1; i >= 0; i--)
            if (!occupied[i]) found = i;
          if (found < 0) begin
            owe(tet_pkg::ST_FULL, '0, 1'b0, 3'd0, 2'd0);
          end else begin
            stored[found].cmd   = req.cmd[0];
            stored[found].outp  = req.outp[2:0];
            stored[found].color = req.color[1:0];
            stored[found].tkey  = now_key;
            occupied[found]     = 1'b1;
            s = found[tet_pkg::SLOT_W-1:0];
            owe(tet_pkg::ST_ADDED, s, 1'b0, 3'd0, 2'd0);
          end
        end
      end
      tet_pkg::OP_DEL: begin
        if (req.idx >= tet_pkg::SLOTS) begin
          owe(tet_pkg::ST_BADSLOT, req.idx, 1'b0, 3'd0, 2'd0);
        end else begin
          occupied[req.idx] = 1'b0;
          owe(tet_pkg::ST_DELETED, req.idx, 1'b0, 3'd0, 2'd0);
        end
      end
      tet_pkg::OP_CHECK: begin
        // Scan upward, firing due slots until the per-check cap is reached
        for (int i = 0; i < tet_pkg::SLOTS; i++) begin
          if (fired < tet_pkg::MAX_OUT && occupied[i] && now_key >= stored[i].tkey) begin
            s = i[tet_pkg::SLOT_W-1:0];
            owe(tet_pkg::ST_FIRED, s, stored[i].cmd, stored[i].outp, stored[i].color);
            occupied[i] = 1'b0;
            fired++;
          end
        end
        if (fired == 0)
          owe(tet_pkg::ST_NONE, '0, 1'b0, 3'd0, 2'd0);
      end
      default: return;  // unused op: nothing owed
    endcase
    owed_results[owed_results.size() - 1].last = 1'b1;
  endfunction

  // Compare one accepted result with the oldest one owed
  task check_result(input tet_pkg::result_t got);
    tet_pkg::result_t want;
    if (owed_results.size() == 0) begin
      report($sformatf("unexpected result status %0d slot %0d", got.status, got.slot));
    end else begin
      want = owed_results.pop_front();
      if (got.status !== want.status || got.slot !== want.slot || got.cmd !== want.cmd ||
          got.outp !== want.outp || got.color !== want.color || got.last !== want.last)
        report($sformatf(
          "got st%0d sl%0d c%0d o%0d k%0d l%0d, want st%0d sl%0d c%0d o%0d k%0d l%0d",
          got.status, got.slot, got.cmd, got.outp, got.color, got.last,
          want.status, want.slot, want.cmd, want.outp, want.color, want.last));
    end
  endtask
endclass

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_FROM   = 75;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_op = '0;
  logic [3:0]                 in_command_code = '0;
  logic [3:0]                 in_output_number = '0;
  logic [3:0]                 in_color_code = '0;
  logic [tet_pkg::SLOT_W-1:0] in_slot_index = '0;
  logic [7:0]                 in_time_year = '0;
  logic [3:0]                 in_time_month = '0;
  logic [4:0]                 in_time_day = '0;
  logic [4:0]                 in_time_hour = '0;
  logic [5:0]                 in_time_minute = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 out_status;
  logic [tet_pkg::SLOT_W-1:0] out_slot;
  logic                       out_fired_command;
  logic [2:0]                 out_fired_output;
  logic [1:0]                 out_fired_color;
  logic                       out_last;

  event_table_board board;
  tet_pkg::result_t got_result;
  bit               quiet = 1'b0;

  timed_event_table_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_command_code   (in_command_code),
    .in_output_number  (in_output_number),
    .in_color_code     (in_color_code),
    .in_slot_index     (in_slot_index),
    .in_time_year      (in_time_year),
    .in_time_month     (in_time_month),
    .in_time_day       (in_time_day),
    .in_time_hour      (in_time_hour),
    .in_time_minute    (in_time_minute),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_fired_command (out_fired_command),
    .out_fired_output  (out_fired_output),
    .out_fired_color   (out_fired_color),
    .out_last          (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic event_request_t make_add(input logic [3:0] cmd, input logic [3:0] outp,
      input logic [3:0] color, input logic [7:0] y, input logic [3:0] mo, input logic [4:0] d,
      input logic [4:0] h, input logic [5:0] mi);
    event_request_t r;
    r = '0;
    r.op = tet_pkg::OP_ADD;
    r.cmd = cmd;
    r.outp = outp;
    r.color = color;
    r.year = y;
    r.month = mo;
    r.day = d;
    r.hour = h;
    r.minute = mi;
    return r;
  endfunction

  function automatic event_request_t make_check(input logic [7:0] y, input logic [3:0] mo,
      input logic [4:0] d, input logic [4:0] h, input logic [5:0] mi);
    event_request_t r;
    r = make_add(4'd0, 4'd0, 4'd0, y, mo, d, h, mi);
    r.op = tet_pkg::OP_CHECK;
    return r;
  endfunction

  function automatic event_request_t make_del(input logic [tet_pkg::SLOT_W-1:0] idx);
    event_request_t r;
    r = '0;
    r.op = tet_pkg::OP_DEL;
    r.idx = idx;
    return r;
  endfunction

  // Drive one request, optionally after an idle burst, and hold it until accepted
  task automatic send(input event_request_t req);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= req.op;
    in_command_code  <= req.cmd;
    in_output_number <= req.outp;
    in_color_code    <= req.color;
    in_slot_index    <= req.idx;
    in_time_year     <= req.year;
    in_time_month    <= req.month;
    in_time_day      <= req.day;
    in_time_hour     <= req.hour;
    in_time_minute   <= req.minute;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.apply_request(req);
  endtask

  // Stall the result channel in random bursts until the quiet tail
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_result.status = tet_pkg::status_t'(out_status);
      got_result.slot   = out_slot;
      got_result.cmd    = out_fired_command;
      got_result.outp   = out_fired_output;
      got_result.color  = out_fired_color;
      got_result.last   = out_last;
      board.check_result(got_result);
    end
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    event_request_t req;
    logic [3:0]     k;
    int             counted;
    int             roll;
    int             add_pct;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty check, each rejection, fill to full, edge deletes, fire all
    send(make_check(8'd0, 4'd0, 5'd0, 5'd0, 6'd0));
    send(make_add(4'd15, 4'd0, 4'd0, 8'd1, 4'd1, 5'd1, 5'd1, 6'd1));
    send(make_add(4'd1, 4'd15, 4'd0, 8'd1, 4'd1, 5'd1, 5'd1, 6'd1));
    send(make_add(4'd0, 4'd7, 4'd15, 8'd1, 4'd1, 5'd1, 5'd1, 6'd1));
    for (int i = 0; i < tet_pkg::SLOTS - 1; i++) begin
      k = i[3:0];
      send(make_add({3'b0, k[0]}, {1'b0, k[2:0]}, {2'b0, k[1:0]},
                    {k, k}, k, {k, 1'b0}, {1'b0, k}, {k, 2'b00}));
    end
    send(make_add(4'd1, 4'd7, 4'd3, 8'd255, 4'd15, 5'd31, 5'd23, 6'd59));
    send(make_add(4'd0, 4'd0, 4'd0, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0));
    send(make_del(7'd99));
    send(make_del(7'd5));
    send(make_add(4'd1, 4'd3, 4'd2, 8'd200, 4'd0, 5'd31, 5'd23, 6'd0));
    send(make_check(8'd255, 4'd15, 5'd31, 5'd23, 6'd59));
    send(make_del(7'd0));
    send(make_del(7'd16));
    req = make_check(8'd255, 4'd15, 5'd31, 5'd23, 6'd59);
    req.op = OP_UNUSED;
    send(req);

    // Random: mostly well-formed adds and checks, with some noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet = (counted >= QUIET_FROM);
      add_pct = (counted < 50) ? 65 : 40;
      roll = $urandom_range(0, 99);
      req.cmd    = 4'($urandom_range(0, 15));
      req.outp   = 4'($urandom_range(0, 15));
      req.color  = 4'($urandom_range(0, 15));
      req.idx    = 7'($urandom_range(0, 99));
      req.year   = 8'($urandom_range(0, 255));
      req.month  = 4'($urandom_range(0, 15));
      req.day    = 5'($urandom_range(0, 31));
      req.hour   = 5'($urandom_range(0, 23));
      req.minute = 6'($urandom_range(0, 59));
      if (roll < add_pct) begin
        req.op = tet_pkg::OP_ADD;
        if ($urandom_range(0, 99) < 85) begin
          req.cmd   = 4'($urandom_range(0, 1));
          req.outp  = 4'($urandom_range(0, 7));
          req.color = 4'($urandom_range(0, 3));
        end
      end else if (roll < add_pct + 30) begin
        req.op = tet_pkg::OP_CHECK;
      end else if (roll < 97) begin
        req.op = tet_pkg::OP_DEL;
        if ($urandom_range(0, 99) < 80)
          req.idx = 7'($urandom_range(0, tet_pkg::SLOTS - 1));
      end else begin
        req.op = OP_UNUSED;
      end
      send(req);
      if (req.op != OP_UNUSED)
        counted++;
    end
    in_valid <= 1'b0;

    // Drain, then allow for any stray result
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.pending() != 0)
      board.report("results still owed at end of run");
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
